[design/mtwo_pkg.sv]
// Shared types, codes and helpers for the multi-table wavetable oscillator.
// No dependencies; used by multi_table_wavetable_oscillator_top.
package mtwo_pkg;

	localparam int unsigned TABLE_DEPTH_DEF = 2048;
	localparam int unsigned TABLE_COUNT_DEF = 8;

	localparam int unsigned PHASE_W  = 27;
	localparam int unsigned FRAC_W   = 16;
	localparam int unsigned SAMPLE_W = 16;
	localparam int unsigned CMD_W    = 3;
	localparam int unsigned TNUM_W   = 3;
	localparam int unsigned INDEX_W  = 11;
	localparam int unsigned LEN_W    = 12;
	localparam int unsigned ATAB_W   = 3;
	localparam int unsigned CFG_W    = 27;
	localparam int unsigned CFG_IDX_W = 2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_TABLE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TABLE_LENGTH = 2'd2;

	localparam logic [PHASE_W-1:0] PHASE_STEP_RST   = 27'd65536;
	localparam logic [ATAB_W-1:0]  ACTIVE_TABLE_RST = 3'd0;
	localparam logic [LEN_W-1:0]   TABLE_LENGTH_RST = 12'd2048;

	typedef enum logic [CMD_W-1:0] {
		CMD_TICK      = 3'd0,
		CMD_WRITE_ONE = 3'd1,
		CMD_ADD_ONE   = 3'd2,
		CMD_WRITE_ALL = 3'd3,
		CMD_ADD_ALL   = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		OP_TICK,
		OP_WRITE,
		OP_ADD
	} op_t;

	typedef logic signed [SAMPLE_W-1:0] sample_t;

	function automatic sample_t sat_add(sample_t a, sample_t b);
		logic signed [SAMPLE_W:0] sum;
		sum = {a[SAMPLE_W-1], a} + {b[SAMPLE_W-1], b};
		if (sum[SAMPLE_W] != sum[SAMPLE_W-1]) begin
			sat_add = sum[SAMPLE_W] ? {1'b1, {(SAMPLE_W-1){1'b0}}} : {1'b0, {(SAMPLE_W-1){1'b1}}};
		end else begin
			sat_add = sum[SAMPLE_W-1:0];
		end
	endfunction

endpackage

[design/mtwo_ram.sv]
// Generic synchronous RAM: one write port, two read ports, registered read data.
// Read during write to the same address returns the old contents. No dependencies.
module mtwo_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end

endmodule

[design/multi_table_wavetable_oscillator_top.sv]
// Top level of the multi-table wavetable oscillator.
// Depends on mtwo_pkg and mtwo_ram (one dual-read RAM bank per table).

// Takes one request per cycle while in_stall is low. A tick shows its interpolated sample
// at the output after stage 1 forms the table addresses, stage 2 gets the table
// data and the product, and stage 3 interpolates into the output register; write and add
// requests return nothing. Every table is its own
// RAM bank with two read ports, so a tick reads both neighbors in the same cycle and a
// write-all or add-all request updates every bank at once; an add is a read, then
// a write one stage later, with the last write forwarded to the following request.
// After reset the block clears all tables, one row of every bank per cycle, and
// holds in_stall high meanwhile; configuration writes are taken
// at any time. A full output register only holds the pipe when a tick is ready.
module multi_table_wavetable_oscillator_top #(
	parameter int unsigned TABLE_DEPTH = mtwo_pkg::TABLE_DEPTH_DEF,
	parameter int unsigned TABLE_COUNT = mtwo_pkg::TABLE_COUNT_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_write,
	input  logic [mtwo_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [mtwo_pkg::CFG_W-1:0]        cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [mtwo_pkg::CMD_W-1:0]        command,
	input  logic [mtwo_pkg::TNUM_W-1:0]       table_number,
	input  logic [mtwo_pkg::INDEX_W-1:0]      sample_index,
	input  logic signed [mtwo_pkg::SAMPLE_W-1:0] sample_value,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [mtwo_pkg::SAMPLE_W-1:0] sample_out
);

	import mtwo_pkg::*;

	localparam int unsigned AW = $clog2(TABLE_DEPTH);
	localparam int unsigned TW = (TABLE_COUNT > 1) ? $clog2(TABLE_COUNT) : 1;
	localparam int unsigned PROD_W = 2 * (SAMPLE_W + 1);

	// configuration
	logic [PHASE_W-1:0] phase_step_q;
	logic [ATAB_W-1:0]  active_table_q;
	logic [LEN_W-1:0]   table_length_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_step_q   <= PHASE_STEP_RST;
			active_table_q <= ACTIVE_TABLE_RST;
			table_length_q <= TABLE_LENGTH_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_PHASE_STEP:   phase_step_q   <= cfg_data[PHASE_W-1:0];
				REG_ACTIVE_TABLE: active_table_q <= cfg_data[ATAB_W-1:0];
				REG_TABLE_LENGTH: table_length_q <= cfg_data[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	logic [LEN_W-1:0] eff_len;
	logic [TW-1:0]    act_tab;

	always_comb begin
		if (table_length_q < LEN_W'(2)) begin
			eff_len = LEN_W'(2);
		end else if (32'(table_length_q) > TABLE_DEPTH) begin
			eff_len = LEN_W'(TABLE_DEPTH);
		end else begin
			eff_len = table_length_q;
		end
		if (32'(active_table_q) >= TABLE_COUNT) begin
			act_tab = TW'(TABLE_COUNT - 1);
		end else begin
			act_tab = TW'(active_table_q);
		end
	end

	// clearing pass after reset
	logic          clr_q;
	logic [AW-1:0] clr_addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_q) begin
			clr_addr_q <= clr_addr_q + AW'(1);
			if (clr_addr_q == AW'(TABLE_DEPTH - 1)) begin
				clr_q <= 1'b0;
			end
		end
	end

	// pipeline control
	logic adv;
	logic acc;
	logic v_s1, v_s2, v_s3;
	logic out_valid_q;

	assign adv      = !(out_valid_q && out_stall && v_s3);
	assign in_stall = clr_q || !adv;
	assign acc      = in_valid && !in_stall;

	// stage 0: decode and phase advance
	cmd_t                   cmd;
	op_t                    op_s0;
	logic                   go_s0;
	logic [TABLE_COUNT-1:0] mask_s0;
	logic                   idx_ok;
	logic                   tnum_ok;
	logic [PHASE_W-1:0]     phase_q;
	logic [PHASE_W:0]       ph_sum;
	logic [PHASE_W:0]       ph_top;
	logic [PHASE_W-1:0]     phase_nx;

	always_comb begin
		cmd     = cmd_t'(command);
		idx_ok  = {1'b0, sample_index} < eff_len;
		tnum_ok = 32'(table_number) < TABLE_COUNT;
		ph_sum  = {1'b0, phase_q} + {1'b0, phase_step_q};
		ph_top  = {eff_len - LEN_W'(1), {FRAC_W{1'b0}}};
		if (ph_sum > ph_top) begin
			phase_nx = PHASE_W'(ph_sum - ph_top);
		end else begin
			phase_nx = ph_sum[PHASE_W-1:0];
		end
		op_s0   = OP_TICK;
		go_s0   = 1'b0;
		mask_s0 = '0;
		case (cmd)
			CMD_TICK: begin
				go_s0 = 1'b1;
			end
			CMD_WRITE_ONE, CMD_ADD_ONE: begin
				op_s0 = (cmd == CMD_ADD_ONE) ? OP_ADD : OP_WRITE;
				go_s0 = idx_ok && tnum_ok;
				for (int b = 0; b < TABLE_COUNT; b++) begin
					mask_s0[b] = (32'(table_number) == 32'(b));
				end
			end
			CMD_WRITE_ALL, CMD_ADD_ALL: begin
				op_s0   = (cmd == CMD_ADD_ALL) ? OP_ADD : OP_WRITE;
				go_s0   = idx_ok;
				mask_s0 = '1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
		end else if (acc && cmd == CMD_TICK) begin
			phase_q <= phase_nx;
		end
	end

	// stage 1: table addresses
	op_t                    op_s1;
	logic [TABLE_COUNT-1:0] mask_s1;
	logic [AW-1:0]          idx_s1;
	sample_t                val_s1;
	logic [PHASE_W-1:0]     phase_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			op_s1    <= op_s0;
			mask_s1  <= mask_s0;
			idx_s1   <= AW'(sample_index);
			val_s1   <= sample_value;
			phase_s1 <= phase_nx;
		end
	end

	logic [LEN_W-1:0] ip_c;
	logic [LEN_W-1:0] ip_n;
	logic [AW-1:0]    rd_addr_a;
	logic [AW-1:0]    rd_addr_b;

	always_comb begin
		if ({1'b0, phase_s1[PHASE_W-1:FRAC_W]} >= eff_len) begin
			ip_c = eff_len - LEN_W'(1);
		end else begin
			ip_c = {1'b0, phase_s1[PHASE_W-1:FRAC_W]};
		end
		ip_n      = (ip_c + LEN_W'(1) == eff_len) ? '0 : ip_c + LEN_W'(1);
		rd_addr_a = (op_s1 == OP_TICK) ? AW'(ip_c) : idx_s1;
		rd_addr_b = AW'(ip_n);
	end

	// stage 2: table data, write back, interpolation product
	op_t                    op_s2;
	logic [TABLE_COUNT-1:0] mask_s2;
	logic [AW-1:0]          addr_a_s2;
	logic [AW-1:0]          addr_b_s2;
	sample_t                val_s2;
	logic [FRAC_W-1:0]      frac_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			op_s2     <= op_s1;
			mask_s2   <= mask_s1;
			addr_a_s2 <= rd_addr_a;
			addr_b_s2 <= rd_addr_b;
			val_s2    <= val_s1;
			frac_s2   <= phase_s1[FRAC_W-1:0];
		end
	end

	logic [SAMPLE_W-1:0]    rda [TABLE_COUNT];
	logic [SAMPLE_W-1:0]    rdb [TABLE_COUNT];
	sample_t                ea [TABLE_COUNT];
	sample_t                eb [TABLE_COUNT];
	sample_t                wdat [TABLE_COUNT];
	logic [TABLE_COUNT-1:0] wen;

	// last write, for the request that read in the same cycle
	logic [TABLE_COUNT-1:0] fw_mask_q;
	logic [AW-1:0]          fw_addr_q;
	sample_t                fw_data_q [TABLE_COUNT];

	always_comb begin
		for (int b = 0; b < TABLE_COUNT; b++) begin
			ea[b] = (fw_mask_q[b] && fw_addr_q == addr_a_s2) ? fw_data_q[b] : sample_t'(rda[b]);
			eb[b] = (fw_mask_q[b] && fw_addr_q == addr_b_s2) ? fw_data_q[b] : sample_t'(rdb[b]);
			wdat[b] = (op_s2 == OP_ADD) ? sat_add(ea[b], val_s2) : val_s2;
			wen[b]  = v_s2 && adv && mask_s2[b];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_mask_q <= '0;
		end else if (adv) begin
			fw_mask_q <= v_s2 ? mask_s2 : '0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			fw_addr_q <= addr_a_s2;
			for (int b = 0; b < TABLE_COUNT; b++) begin
				fw_data_q[b] <= wdat[b];
			end
		end
	end

	sample_t                   samp_a;
	sample_t                   samp_b;
	logic signed [SAMPLE_W:0]  diff;
	logic signed [PROD_W-1:0]  prod;

	always_comb begin
		samp_a = ea[act_tab];
		samp_b = eb[act_tab];
		diff   = {samp_b[SAMPLE_W-1], samp_b} - {samp_a[SAMPLE_W-1], samp_a};
		prod   = diff * $signed({1'b0, frac_s2});
	end

	genvar gb;
	generate
		for (gb = 0; gb < TABLE_COUNT; gb++) begin : g_bank
			mtwo_ram #(
				.WIDTH(SAMPLE_W),
				.DEPTH(TABLE_DEPTH)
			) u_ram (
				.clk     (clk),
				.we      (clr_q || wen[gb]),
				.waddr   (clr_q ? clr_addr_q : addr_a_s2),
				.wdata   (clr_q ? '0 : wdat[gb]),
				.re      (adv),
				.raddr_a (rd_addr_a),
				.raddr_b (rd_addr_b),
				.rdata_a (rda[gb]),
				.rdata_b (rdb[gb])
			);
		end
	endgenerate

	// stage 3: floor of product / 2^16, add base sample
	sample_t                  a_s3;
	logic signed [PROD_W-1:0] prod_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			a_s3    <= samp_a;
			prod_s3 <= prod;
		end
	end

	logic signed [PROD_W-FRAC_W-1:0] delta;
	logic signed [PROD_W-FRAC_W-1:0] interp;

	always_comb begin
		delta  = prod_s3[PROD_W-1:FRAC_W];
		interp = (PROD_W-FRAC_W)'(a_s3) + delta;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= acc && go_s0;
			v_s2 <= v_s1;
			v_s3 <= v_s2 && op_s2 == OP_TICK;
		end
	end

	// output register
	sample_t sample_out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && v_s3) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && v_s3) begin
			sample_out_q <= interp[SAMPLE_W-1:0];
		end
	end

	assign out_valid  = out_valid_q;
	assign sample_out = sample_out_q;

`ifndef SYNTHESIS
	a_clear_empty: assert property (@(posedge clk) disable iff (!arst_n)
		clr_q |-> (!v_s1 && !v_s2 && !v_s3))
		else $error("request in flight during table clearing");

	a_tick_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && op_s1 == OP_TICK) |-> (ip_c < eff_len && ip_n < eff_len))
		else $error("tick read address beyond table length");

	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && !adv) |=> (v_s3 && $stable(prod_s3) && $stable(a_s3)))
		else $error("pending tick lost while output held");
`endif

endmodule

[bench/multi_table_wavetable_oscillator_top_tb.sv]
// Self-checking bench for multi_table_wavetable_oscillator_top: random ticks, table writes
// and adds under several register settings, checked against a table/phase mirror.
// Depends on mtwo_pkg and the oscillator RTL only.
`timescale 1ns / 100ps

module multi_table_wavetable_oscillator_top_tb;
	import mtwo_pkg::*;

	localparam int SAMPLE_MAX   = 2 ** (SAMPLE_W - 1) - 1;
	localparam int SAMPLE_MIN   = -(2 ** (SAMPLE_W - 1));
	localparam int DRAIN_CYCLES = 8;
	localparam int PHASES       = 10;
	localparam int PER_PHASE    = 150;

	// Mirror of the wave tables, phase accumulator and registers; holds the
	// samples that accepted ticks still owe.
	class wavetable_mirror;
		sample_t wave[TABLE_COUNT_DEF][TABLE_DEPTH_DEF];
		logic [PHASE_W-1:0] phase;
		logic [PHASE_W-1:0] phase_inc;
		logic [ATAB_W-1:0] sel_table;
		logic [LEN_W-1:0] len_reg;
		sample_t due_samples[$];
		int mismatches;
		int requests;
		int ticks;
		int checked;

		function new();
			foreach (wave[t, i]) wave[t][i] = '0;
			phase = '0;
			phase_inc = PHASE_STEP_RST;
			sel_table = ACTIVE_TABLE_RST;
			len_reg = TABLE_LENGTH_RST;
			mismatches = 0;
			requests = 0;
			ticks = 0;
			checked = 0;
		endfunction

		static function int unsigned fit_length(int unsigned n);
			if (n < 2) return 2;
			if (n > TABLE_DEPTH_DEF) return TABLE_DEPTH_DEF;
			return n;
		endfunction

		function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
			case (idx)
				REG_PHASE_STEP:   phase_inc = data[PHASE_W-1:0];
				REG_ACTIVE_TABLE: sel_table = data[ATAB_W-1:0];
				REG_TABLE_LENGTH: len_reg = data[LEN_W-1:0];
				default: ;
			endcase
		endfunction

		function void store(int unsigned t, int unsigned idx, sample_t v, bit accumulate);
			int s;
			if (!accumulate) begin
				wave[t][idx] = v;
				return;
			end
			s = int'(wave[t][idx]) + int'(v);
			if (s > SAMPLE_MAX) s = SAMPLE_MAX;
			else if (s < SAMPLE_MIN) s = SAMPLE_MIN;
			wave[t][idx] = sample_t'(s);
		endfunction

		// phase advance with a single wrap, then linear interpolation
		function sample_t advance();
			int unsigned len;
			int unsigned ip;
			int unsigned nxt;
			int unsigned t;
			longint unsigned sum;
			longint unsigned top;
			longint a;
			longint b;
			longint frac;
			longint prod;
			len = fit_length(len_reg);
			sum = longint'(phase) + longint'(phase_inc);
			top = longint'(len - 1) << FRAC_W;
			if (sum > top) sum = sum - top;
			phase = sum[PHASE_W-1:0];
			ip = phase >> FRAC_W;
			frac = phase[FRAC_W-1:0];
			if (ip >= len) ip = len - 1;
			nxt = (ip + 1) % len;
			t = (sel_table >= TABLE_COUNT_DEF) ? TABLE_COUNT_DEF - 1 : sel_table;
			a = wave[t][ip];
			b = wave[t][nxt];
			prod = (b - a) * frac;
			// arithmetic shift gives the floor, also for negative slopes
			return sample_t'(a + (prod >>> FRAC_W));
		endfunction

		function void take_request(logic [CMD_W-1:0] cmd, logic [TNUM_W-1:0] tnum,
				logic [INDEX_W-1:0] idx, sample_t val);
			requests++;
			if (cmd == CMD_TICK) begin
				due_samples.push_back(advance());
				ticks++;
				return;
			end
			if (idx >= fit_length(len_reg)) return;
			case (cmd)
				CMD_WRITE_ONE, CMD_ADD_ONE:
					if (tnum < TABLE_COUNT_DEF) store(tnum, idx, val, cmd == CMD_ADD_ONE);
				CMD_WRITE_ALL, CMD_ADD_ALL:
					for (int t = 0; t < TABLE_COUNT_DEF; t++) store(t, idx, val, cmd == CMD_ADD_ALL);
				default: ;
			endcase
		endfunction

		function void check_sample(sample_t got);
			sample_t want;
			if (due_samples.size() == 0) begin
				$error("sample_out: unexpected result, expected none, actual %0d", got);
				mismatches++;
				return;
			end
			want = due_samples.pop_front();
			checked++;
			if (got !== want) begin
				$error("sample_out: expected %0d, actual %0d", want, got);
				mismatches++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_write;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;
	logic in_valid;
	logic in_stall;
	logic [CMD_W-1:0] command;
	logic [TNUM_W-1:0] table_number;
	logic [INDEX_W-1:0] sample_index;
	logic signed [SAMPLE_W-1:0] sample_value;
	logic out_valid;
	logic out_stall;
	logic signed [SAMPLE_W-1:0] sample_out;

	wavetable_mirror sb = new();
	int unsigned cur_len;
	int unsigned cur_table;
	int gap_odds;
	bit calm;
	int settings;

	multi_table_wavetable_oscillator_top i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.command      (command),
		.table_number (table_number),
		.sample_index (sample_index),
		.sample_value (sample_value),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.sample_out   (sample_out)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("multi_table_wavetable_oscillator_top_tb failed");
		$finish;
	end

	// everything sampled here holds its pre-edge value
	always @(posedge clk) begin
		if (cfg_write) sb.set_register(cfg_index, cfg_data);
		if (in_valid && !in_stall) sb.take_request(command, table_number, sample_index, sample_value);
		if (out_valid && !out_stall) sb.check_sample(sample_out);
	end

	initial begin
		out_stall <= 1'b0;
		@(posedge clk);
		forever begin
			if (!calm && $urandom_range(0, 2) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 7)) @(posedge clk);
				out_stall <= 1'b0;
			end
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	end

	task automatic send(input logic [CMD_W-1:0] cmd, input logic [TNUM_W-1:0] tnum,
			input logic [INDEX_W-1:0] idx, input sample_t val);
		if (gap_odds != 0 && $urandom_range(0, 99) < gap_odds) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		table_number <= tnum;
		sample_index <= idx;
		sample_value <= val;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
	endtask

	// registers change only with the pipe empty; writes and adds may trail the last tick
	task automatic settle_and_configure(input int unsigned inc, input int unsigned tab,
			input int unsigned len);
		in_valid <= 1'b0;
		while (sb.due_samples.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		write_reg(REG_PHASE_STEP, CFG_W'(inc));
		write_reg(REG_ACTIVE_TABLE, CFG_W'(tab));
		write_reg(REG_TABLE_LENGTH, CFG_W'(len));
		cfg_write <= 1'b0;
		cur_len = wavetable_mirror::fit_length(len);
		cur_table = tab;
		settings++;
	endtask

	task automatic hold_until_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (sb.due_samples.size() != 0);
	endtask

	task automatic random_request(output bit counted);
		int r;
		int unsigned ip;
		logic [CMD_W-1:0] cmd;
		logic [TNUM_W-1:0] tnum;
		logic [INDEX_W-1:0] idx;
		sample_t val;
		r = $urandom_range(0, 99);
		val = sample_t'($urandom);
		if ($urandom_range(0, 9) == 0) begin
			val = $urandom_range(0, 1) ? sample_t'(SAMPLE_MAX) : sample_t'(SAMPLE_MIN);
		end
		tnum = ($urandom_range(0, 3) == 0) ? TNUM_W'($urandom) : TNUM_W'(cur_table);
		idx = INDEX_W'($urandom);
		if (r < 45) begin
			cmd = CMD_TICK;
		end else if (r < 88) begin
			cmd = CMD_W'($urandom_range(CMD_WRITE_ONE, CMD_ADD_ALL));
			// half of the updates land just ahead of the read position
			if ($urandom_range(0, 1)) begin
				ip = sb.phase >> FRAC_W;
				idx = INDEX_W'((ip + $urandom_range(0, 6)) % cur_len);
			end else begin
				idx = INDEX_W'($urandom_range(0, cur_len - 1));
			end
		end else begin
			cmd = CMD_W'($urandom);
		end
		send(cmd, tnum, idx, val);
		counted = (cmd == CMD_TICK) || (cmd <= CMD_ADD_ALL && idx < cur_len);
	endtask

	initial begin
		int unsigned len;
		int unsigned inc;
		int done;
		bit counted;
		bit held;
		arst_n <= 1'b0;
		cfg_write <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		in_valid <= 1'b0;
		command <= '0;
		table_number <= '0;
		sample_index <= '0;
		sample_value <= '0;
		calm = 1'b0;
		gap_odds = 0;
		settings = 0;
		held = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// directed: extremes, saturation both ways, ignored requests, wrap and clamps
		settle_and_configure(32'h0000_C000, 0, 8);
		send(CMD_WRITE_ONE, 0, 0, sample_t'(SAMPLE_MAX));
		send(CMD_WRITE_ONE, 0, 1, sample_t'(SAMPLE_MIN));
		send(CMD_WRITE_ALL, 0, 2, 12345);
		send(CMD_ADD_ONE, 0, 0, sample_t'(SAMPLE_MAX));
		send(CMD_ADD_ALL, 0, 1, -1);
		send(CMD_ADD_ALL, 0, 3, sample_t'(SAMPLE_MIN));
		send(CMD_ADD_ONE, 0, 3, sample_t'(SAMPLE_MIN));
		send(CMD_WRITE_ONE, 7, 7, -5);
		send(CMD_WRITE_ONE, 0, 8, 999);
		send(CMD_WRITE_ALL, 0, 2047, 777);
		for (int c = CMD_ADD_ALL + 1; c < 2 ** CMD_W; c++) send(CMD_W'(c), '0, '0, sample_t'(c));
		repeat (5) send(CMD_TICK, 0, 0, 0);
		settle_and_configure(2 ** PHASE_W - 1, 7, 4095);
		repeat (3) send(CMD_TICK, 0, 0, 0);
		settle_and_configure(0, 0, 0);
		send(CMD_WRITE_ONE, 0, 2, 4321);
		repeat (2) send(CMD_TICK, 0, 0, 0);
		settle_and_configure(1, 3, 1);
		send(CMD_TICK, 0, 0, 0);

		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: len = 2048;
				1: len = 2;
				2: len = 4095;
				3: len = 0;
				default: len = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 2048)
						: $urandom_range(3, 64);
			endcase
			case ($urandom_range(0, 7))
				0: inc = 0;
				1: inc = 2 ** PHASE_W - 1;
				2: inc = $urandom_range(0, 2 ** PHASE_W - 1);
				default: inc = $urandom_range(1, wavetable_mirror::fit_length(len) * 65536 / 4);
			endcase
			if (p == PHASES - 1) begin
				calm = 1'b1;
				gap_odds = 0;
			end else begin
				gap_odds = (p % 4 == 1) ? 0 : $urandom_range(10, 40);
			end
			settle_and_configure(inc, $urandom_range(0, TABLE_COUNT_DEF - 1), len);
			done = 0;
			while (done < PER_PHASE) begin
				if (p == 4 && done == 80 && !held) begin
					hold_until_drained();
					held = 1'b1;
				end
				random_request(counted);
				if (counted) done++;
			end
		end

		in_valid <= 1'b0;
		for (int w = 0; w < 4000 && sb.due_samples.size() != 0; w++) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.due_samples.size() != 0) begin
			$error("sample_out: expected %0d more samples, actual none", sb.due_samples.size());
			sb.mismatches++;
		end
		$display("Run: %0d requests (%0d ticks), %0d samples checked, %0d register settings",
				sb.requests, sb.ticks, sb.checked, settings);
		$display("Covered writes/adds to one and all tables, saturation, ignored indexes/codes");
		if (sb.mismatches == 0) begin
			$display("multi_table_wavetable_oscillator_top_tb passed");
		end else begin
			$display("multi_table_wavetable_oscillator_top_tb failed");
		end
		$finish;
	end
endmodule

[filelist.f]
design/mtwo_pkg.sv
design/mtwo_ram.sv
design/multi_table_wavetable_oscillator_top.sv
bench/multi_table_wavetable_oscillator_top_tb.sv
